// File: rtl/pic_pkg.sv
`timescale 1ns / 1ps
package pic_pkg;

	localparam int unsigned NUM_LINES = 8;
	localparam int unsigned LINE_IDX_W = $clog2(NUM_LINES);
	localparam int unsigned PRIO_W = LINE_IDX_W + 1;

	// Beat command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_LINES = 2'd2;
	localparam logic [1:0] CMD_ACK   = 2'd3;

	localparam logic PORT_CMD  = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	// Init sequence phases
	localparam logic [1:0] PH_READY = 2'd0;
	localparam logic [1:0] PH_ICW2  = 2'd1;
	localparam logic [1:0] PH_ICW3  = 2'd2;
	localparam logic [1:0] PH_ICW4  = 2'd3;

	// Mode flag bit positions
	localparam int unsigned MF_IC4  = 0;
	localparam int unsigned MF_SNGL = 1;
	localparam int unsigned MF_RIS  = 2;
	localparam int unsigned MF_LTIM = 3;
	localparam int unsigned MF_UPM  = 4;
	localparam int unsigned MF_W    = 5;

	// Command-port write decode
	localparam int unsigned ICW1_BIT   = 4;
	localparam int unsigned OCW3_BIT   = 3;
	localparam int unsigned OCW3_RR    = 1;
	localparam int unsigned OCW3_RIS   = 0;
	localparam int unsigned ICW4_UPM   = 0;
	localparam logic [7:0] ICW1_KEEP   = 8'h0b;
	localparam logic [2:0] EOI_NS      = 3'b001;
	localparam logic [2:0] EOI_NS_ROT  = 3'b101;
	localparam logic [2:0] EOI_SP      = 3'b011;
	localparam logic [2:0] EOI_SP_ROT  = 3'b111;

	localparam int unsigned BASE_W = 5;
	localparam logic [LINE_IDX_W-1:0] SPURIOUS_LINE = '1;

	typedef logic [NUM_LINES-1:0] lines_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       int_pending;
		logic [7:0] vector;
		logic       spurious;
	} result_t;

	// Index of the lowest set bit, NUM_LINES when none is set
	function automatic logic [PRIO_W-1:0] lowest_bit(input lines_t v);
		logic [PRIO_W-1:0] idx;
		idx = PRIO_W'(NUM_LINES);
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = PRIO_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: rtl/pic_if.sv
`timescale 1ns / 1ps
interface pic_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       port_sel;
	logic [7:0] wdata;
	logic [7:0] req_lines;

	modport source(output valid, cmd, port_sel, wdata, req_lines, input ready);
	modport sink(input valid, cmd, port_sel, wdata, req_lines, output ready);
endinterface

interface pic_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rdata;
	logic       int_pending;
	logic [7:0] vector;
	logic       spurious;

	modport source(output valid, rdata, int_pending, vector, spurious, input ready);
	modport sink(input valid, rdata, int_pending, vector, spurious, output ready);
endinterface

// File: rtl/programmable_interrupt_controller_core.sv
`timescale 1ns / 1ps
// Single 8259-style interrupt controller with fixed priority (IRQ0 highest). Every request
// beat is a bus write, a bus read, a sample of the eight request lines or an interrupt
// acknowledge, and each gives exactly one response beat. A beat is decoded and applied to the
// controller registers in the cycle it is accepted, and its response is captured in an
// output register at that edge; a new beat is taken every clock as long as the response
// register is empty or being drained, so the throughput is one beat per clock.
// Rotation, poll, special mask, buffered mode and cascading are not supported.
module programmable_interrupt_controller_core (
	input  logic       clk,
	input  logic       arst_n,
	pic_req_if.sink    req_ch,
	pic_rsp_if.source  rsp_ch
);

	pic_pkg::lines_t imr_q, isr_q, irr_q, prev_q;
	pic_pkg::lines_t imr_n, isr_n, irr_n;
	logic [pic_pkg::BASE_W-1:0] base_q, base_n;
	logic [7:0] cascade_q, cascade_n;
	logic [1:0] phase_q, phase_n;
	logic [pic_pkg::MF_W-1:0] mode_q, mode_n;

	pic_pkg::result_t res_n, res_q;
	logic out_valid_q;
	logic accept;

	logic [pic_pkg::PRIO_W-1:0] grant_now, limit_now, grant_nx, limit_nx;
	logic [pic_pkg::PRIO_W-1:0] isr_low;
	logic [2:0] eoi_code;

	assign req_ch.ready = !out_valid_q || rsp_ch.ready;
	assign accept = req_ch.valid && req_ch.ready;

	assign eoi_code = req_ch.wdata[7:5];
	assign isr_low  = pic_pkg::lowest_bit(isr_q);

	always_comb begin
		limit_now = isr_low;
		grant_now = pic_pkg::lowest_bit(irr_q & ~imr_q);
		if (grant_now >= limit_now) begin
			grant_now = pic_pkg::PRIO_W'(pic_pkg::NUM_LINES);
		end
	end

	always_comb begin
		imr_n = imr_q;
		isr_n = isr_q;
		irr_n = irr_q;
		base_n = base_q;
		cascade_n = cascade_q;
		phase_n = phase_q;
		mode_n = mode_q;
		res_n = '0;
		case (req_ch.cmd)
			pic_pkg::CMD_WRITE: begin
				if (req_ch.port_sel == pic_pkg::PORT_DATA) begin
					case (phase_q)
						pic_pkg::PH_ICW2: begin
							base_n = req_ch.wdata[7:3];
							if (mode_q[pic_pkg::MF_SNGL]) begin
								phase_n = mode_q[pic_pkg::MF_IC4] ? pic_pkg::PH_ICW4
									: pic_pkg::PH_READY;
							end else begin
								phase_n = pic_pkg::PH_ICW3;
							end
						end
						pic_pkg::PH_ICW3: begin
							cascade_n = req_ch.wdata;
							phase_n = mode_q[pic_pkg::MF_IC4] ? pic_pkg::PH_ICW4
								: pic_pkg::PH_READY;
						end
						pic_pkg::PH_ICW4: begin
							mode_n[pic_pkg::MF_UPM] = req_ch.wdata[pic_pkg::ICW4_UPM];
							phase_n = pic_pkg::PH_READY;
						end
						default: begin
							imr_n = req_ch.wdata;
						end
					endcase
				end else if (req_ch.wdata[pic_pkg::ICW1_BIT]) begin
					mode_n = pic_pkg::MF_W'(req_ch.wdata & pic_pkg::ICW1_KEEP);
					imr_n = '0;
					isr_n = '0;
					irr_n = '0;
					phase_n = pic_pkg::PH_ICW2;
				end else if (req_ch.wdata[pic_pkg::OCW3_BIT]) begin
					if (req_ch.wdata[pic_pkg::OCW3_RR]) begin
						mode_n[pic_pkg::MF_RIS] = req_ch.wdata[pic_pkg::OCW3_RIS];
					end
				end else if (eoi_code == pic_pkg::EOI_NS || eoi_code == pic_pkg::EOI_NS_ROT) begin
					if (isr_low < pic_pkg::PRIO_W'(pic_pkg::NUM_LINES)) begin
						isr_n[isr_low[pic_pkg::LINE_IDX_W-1:0]] = 1'b0;
					end
				end else if (eoi_code == pic_pkg::EOI_SP || eoi_code == pic_pkg::EOI_SP_ROT) begin
					isr_n[req_ch.wdata[pic_pkg::LINE_IDX_W-1:0]] = 1'b0;
				end
			end
			pic_pkg::CMD_READ: begin
				if (req_ch.port_sel == pic_pkg::PORT_DATA) begin
					res_n.rdata = imr_q;
				end else begin
					res_n.rdata = mode_q[pic_pkg::MF_RIS] ? isr_q : irr_q;
				end
			end
			pic_pkg::CMD_LINES: begin
				if (mode_q[pic_pkg::MF_LTIM]) begin
					irr_n = req_ch.req_lines;
				end else begin
					irr_n = irr_q | (req_ch.req_lines & ~prev_q);
				end
			end
			default: begin
				if (grant_now < pic_pkg::PRIO_W'(pic_pkg::NUM_LINES)) begin
					isr_n[grant_now[pic_pkg::LINE_IDX_W-1:0]] = 1'b1;
					irr_n[grant_now[pic_pkg::LINE_IDX_W-1:0]] = 1'b0;
					res_n.vector = {base_q, grant_now[pic_pkg::LINE_IDX_W-1:0]};
				end else begin
					res_n.vector = {base_q, pic_pkg::SPURIOUS_LINE};
					res_n.spurious = 1'b1;
				end
			end
		endcase

		// Pending flag looks at the state left by this beat
		limit_nx = pic_pkg::lowest_bit(isr_n);
		grant_nx = pic_pkg::lowest_bit(irr_n & ~imr_n);
		res_n.int_pending = grant_nx < limit_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imr_q <= '0;
			isr_q <= '0;
			irr_q <= '0;
			prev_q <= '0;
			base_q <= '0;
			cascade_q <= '0;
			phase_q <= pic_pkg::PH_READY;
			mode_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				imr_q <= imr_n;
				isr_q <= isr_n;
				irr_q <= irr_n;
				base_q <= base_n;
				cascade_q <= cascade_n;
				phase_q <= phase_n;
				mode_q <= mode_n;
				if (req_ch.cmd == pic_pkg::CMD_LINES) begin
					prev_q <= req_ch.req_lines;
				end
				out_valid_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, held while the sink stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.rdata       = res_q.rdata;
	assign rsp_ch.int_pending = res_q.int_pending;
	assign rsp_ch.vector      = res_q.vector;
	assign rsp_ch.spurious    = res_q.spurious;

	a_spurious_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.spurious |-> res_q.vector[2:0] == pic_pkg::SPURIOUS_LINE)
		else $error("spurious response without line 7 vector");

	a_grant_sets_isr: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_ch.cmd == pic_pkg::CMD_ACK && !res_n.spurious |=> isr_q != '0)
		else $error("granted acknowledge left ISR empty");

	a_icw1_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_ch.cmd == pic_pkg::CMD_WRITE && req_ch.port_sel == pic_pkg::PORT_CMD
		&& req_ch.wdata[pic_pkg::ICW1_BIT] |=> phase_q == pic_pkg::PH_ICW2 && isr_q == '0)
		else $error("ICW1 did not restart init");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp_ch.ready |=> out_valid_q && $stable(res_q))
		else $error("stalled response lost");

endmodule
